/* src/backend_round_robin_health_select_unit_macros.svh */
// assertion macros for the backend select unit
`ifndef BACKEND_ROUND_ROBIN_HEALTH_SELECT_UNIT_MACROS_SVH
`define BACKEND_ROUND_ROBIN_HEALTH_SELECT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define BRHS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define BRHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BRHS_ASSERT_IMPLY(label, ante, cons)
`define BRHS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/brhs_pkg.sv */
package brhs_pkg;

    localparam int COUNT_W   = 5;
    localparam int RETRY_W   = 16;
    localparam int TIME_W    = 32;
    localparam int INDEX_W   = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_SEL_W = 1;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_FAIL   = 1'b1;

    localparam logic [CFG_SEL_W-1:0] REG_BACKEND_COUNT = 1'd0;
    localparam logic [CFG_SEL_W-1:0] REG_RETRY_SECONDS = 1'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 16'd30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PREP,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic mark;
        logic prep;
        logic probe;
        logic load;
    } ctl_cmd_t;

    typedef struct packed {
        logic fail_op;
        logic hit;
        logic last_probe;
        logic out_free;
    } dp_status_t;

endpackage

/* src/brhs_req_if.sv */
interface brhs_req_if
    import brhs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, output op, output now_seconds, input ready);
    modport sink (input valid, input op, input now_seconds, output ready);
endinterface

/* src/brhs_rsp_if.sv */
interface brhs_rsp_if
    import brhs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] backend_index;

    modport source (output valid, output found, output backend_index, input ready);
    modport sink (input valid, input found, input backend_index, output ready);
endinterface

/* src/brhs_ctrl.sv */
module brhs_ctrl
    import brhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.fail_op ? ST_MARK : ST_PREP;
                end
            end
            ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (status.hit || status.last_probe)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/brhs_dpath.sv */
module brhs_dpath
    import brhs_pkg::*;
#(
    parameter int MAX_BACKENDS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_SEL_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_op,
    input  logic [TIME_W-1:0]    req_now,
    input  ctl_cmd_t             cmd,
    output dp_status_t           status,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output logic                 rsp_found,
    output logic [INDEX_W-1:0]   rsp_index
);

    localparam int IW  = $clog2(MAX_BACKENDS);
    localparam int W   = (IW > COUNT_W) ? IW : COUNT_W;
    localparam int CAP = (MAX_BACKENDS < 31) ? MAX_BACKENDS : 31;

    logic [COUNT_W-1:0]    count_reg;
    logic [RETRY_W-1:0]    retry_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [MAX_BACKENDS-1:0] dead_reg;
    logic [TIME_W-1:0]     revive_mem [MAX_BACKENDS];
    logic [TIME_W-1:0]     rd_data_reg;
    logic [IW-1:0]         pool_reg;
    logic [W-1:0]          sc_reg;
    logic [IW-1:0]         last_reg;
    logic [IW-1:0]         addr_reg;
    logic [COUNT_W-1:0]    tried_reg;
    logic                  found_pend_reg;
    logic [IW-1:0]         pick_pend_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [INDEX_W-1:0]    out_index_reg;

    logic [COUNT_W-1:0] n;
    logic [W-1:0]       nw;
    logic [W-1:0]       pool_w;
    logic [W-1:0]       start;
    logic [W-1:0]       start_inc;
    logic [W-1:0]       pool_next;
    logic [W-1:0]       resume;
    logic [W-1:0]       addr_inc;
    logic [W-1:0]       next_addr;
    logic [IW-1:0]      rd_addr;
    logic               is_dead;
    logic               revive;
    logic               hit;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  deadline;

    // effective count, clamped to the pool size
    always_comb
    begin
        if (count_reg == '0)
        begin
            n = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(CAP))
        begin
            n = COUNT_W'(CAP);
        end
        else
        begin
            n = count_reg;
        end
    end

    assign nw        = W'(n);
    assign pool_w    = W'(pool_reg);
    assign start     = (pool_w >= nw) ? '0 : pool_w;
    assign start_inc = start + W'(1);
    assign pool_next = (start_inc >= nw) ? '0 : start_inc;
    assign resume    = (sc_reg >= nw) ? '0 : sc_reg;
    assign addr_inc  = W'(addr_reg) + W'(1);
    assign next_addr = (addr_inc >= nw) ? '0 : addr_inc;
    assign rd_addr   = cmd.probe ? IW'(next_addr) : addr_reg;

    assign is_dead = dead_reg[addr_reg];
    assign revive  = is_dead && (now_reg >= rd_data_reg);
    assign hit     = !is_dead || revive;

    // saturating retry deadline
    assign sum      = {1'b0, now_reg} + (TIME_W + 1)'(retry_reg);
    assign deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    assign status.fail_op    = (req_op == OP_FAIL);
    assign status.hit        = hit;
    assign status.last_probe = (tried_reg == n);
    assign status.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp_found = out_found_reg;
    assign rsp_index = out_index_reg;

    // revive time store
    always_ff @(posedge clk)
    begin
        if (cmd.mark)
        begin
            revive_mem[last_reg] <= deadline;
        end
        rd_data_reg <= revive_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            now_reg <= req_now;
        end
        if (cmd.probe && hit)
        begin
            pick_pend_reg <= addr_reg;
        end
        if (cmd.load)
        begin
            out_found_reg <= found_pend_reg;
            out_index_reg <= found_pend_reg ? INDEX_W'(W'(pick_pend_reg)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_RESET;
            retry_reg      <= RETRY_RESET;
            dead_reg       <= '0;
            pool_reg       <= '0;
            sc_reg         <= '0;
            last_reg       <= '0;
            addr_reg       <= '0;
            tried_reg      <= '0;
            found_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BACKEND_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    REG_RETRY_SECONDS: retry_reg <= cfg_data[RETRY_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.start)
            begin
                tried_reg      <= '0;
                found_pend_reg <= 1'b0;
                if (req_op == OP_FAIL)
                begin
                    addr_reg <= IW'(resume);
                end
                else
                begin
                    addr_reg <= IW'(start);
                    pool_reg <= IW'(pool_next);
                end
            end
            if (cmd.mark)
            begin
                dead_reg[last_reg] <= 1'b1;
            end
            if (cmd.probe)
            begin
                if (revive)
                begin
                    dead_reg[addr_reg] <= 1'b0;
                end
                sc_reg    <= addr_inc;
                addr_reg  <= IW'(next_addr);
                tried_reg <= tried_reg + COUNT_W'(1);
                if (hit)
                begin
                    found_pend_reg <= 1'b1;
                    last_reg       <= addr_reg;
                end
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* src/backend_round_robin_health_select_unit.sv */
// channel   dir  payload                       handshake
// req       in   op, now_seconds               valid/ready
// rsp       out  found, backend_index          valid/ready
// cfg       in   cfg_index, cfg_data           cfg_we, no wait
//
// a request passes IDLE, PREP, the PROBE loop and DONE; a failure report adds MARK before PREP,
// and the loop probes 1 to n+1 entries, n being the clamped count (up to 17 at 16 backends)
// the probe loop checks one entry per cycle through the revive-time read port
// one request is in work at a time; a finished result waits in the output register
// reset clears the dead flags at once, no clearing pass is needed
`include "backend_round_robin_health_select_unit_macros.svh"

module backend_round_robin_health_select_unit
    import brhs_pkg::*;
#(
    parameter int MAX_BACKENDS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    brhs_req_if.sink             req,
    brhs_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_SEL_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    brhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    brhs_dpath #(
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_op    (req.op),
        .req_now   (req.now_seconds),
        .cmd       (cmd),
        .status    (status),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_found (rsp.found),
        .rsp_index (rsp.backend_index)
    );

    `BRHS_ASSERT_NEXT(a_accept_then_busy, req.valid && req.ready, !req.ready)
    `BRHS_ASSERT_IMPLY(a_none_zero_index, rsp.valid && !rsp.found, rsp.backend_index == '0)
    `BRHS_ASSERT_NEXT(a_load_shows_result, cmd.load, rsp.valid)

endmodule

/* tb/tb_backend_round_robin_health_select_unit.sv */
`timescale 1ns / 1ps

module tb_backend_round_robin_health_select_unit;
    import brhs_pkg::*;

    localparam int NUM_BACKENDS = 16;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] backend_index;
    } pick_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_SEL_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    brhs_req_if req_ch();
    brhs_rsp_if rsp_ch();

    backend_round_robin_health_select_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // predicted pool state
    logic               backend_dead [NUM_BACKENDS];
    logic [TIME_W-1:0]  revive_at [NUM_BACKENDS];
    logic [INDEX_W-1:0] pool_pos;
    logic [COUNT_W-1:0] probe_pos;
    logic [INDEX_W-1:0] prev_pick;
    logic [COUNT_W-1:0] count_reg;
    logic [RETRY_W-1:0] retry_reg;

    pick_t pending_picks[$];
    int    error_count = 0;
    bit    gaps_on = 1'b1;
    int    rsp_hold_cycles = 0;
    int    stall_cycles = 0;

    function automatic int draw_gap();
        if (!gaps_on || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic pick_t select_backend(input logic op, input logic [TIME_W-1:0] now);
        int            n;
        int            c;
        int            tries;
        logic [TIME_W:0] deadline;
        pick_t         r;
        r = '0;
        n = (count_reg == 0) ? 1 : (count_reg > NUM_BACKENDS) ? NUM_BACKENDS : int'(count_reg);
        if (op == OP_SELECT)
        begin
            c = (pool_pos >= n) ? 0 : int'(pool_pos);
            probe_pos = COUNT_W'(c);
            pool_pos = (c + 1 >= n) ? '0 : INDEX_W'(c + 1);
        end
        else
        begin
            // deadline saturates at the top of the time range
            deadline = (TIME_W+1)'(now) + (TIME_W+1)'(retry_reg);
            backend_dead[prev_pick] = 1'b1;
            revive_at[prev_pick] = deadline[TIME_W] ? '1 : deadline[TIME_W-1:0];
        end
        for (tries = 0; tries <= n; tries++)
        begin
            c = (probe_pos >= n) ? 0 : int'(probe_pos);
            if (backend_dead[c] && now >= revive_at[c])
                backend_dead[c] = 1'b0;
            probe_pos = COUNT_W'(c + 1);
            if (!backend_dead[c])
            begin
                r.found = 1'b1;
                r.backend_index = INDEX_W'(c);
                prev_pick = INDEX_W'(c);
                return r;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic op, input logic [TIME_W-1:0] now);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.now_seconds <= now;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pending_picks.insert(pending_picks.size(), select_backend(op, now));
    endtask

    task automatic drain_picks();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_picks.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_SEL_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BACKEND_COUNT: count_reg = data[COUNT_W-1:0];
            REG_RETRY_SECONDS: retry_reg = data[RETRY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_failure_before_pick();
        // reset config: one backend, 30 s retry
        send_request(OP_FAIL, 32'd5);
        send_request(OP_FAIL, 32'd10);
        send_request(OP_SELECT, 32'd39);
        send_request(OP_SELECT, 32'd40);
        drain_picks();
    endtask

    task automatic test_zero_retry();
        write_register(REG_RETRY_SECONDS, 16'd0);
        send_request(OP_FAIL, 32'd50);
        drain_picks();
        write_register(REG_BACKEND_COUNT, 16'd16);
        send_request(OP_SELECT, 32'd60);
        send_request(OP_FAIL, 32'd61);
        send_request(OP_SELECT, 32'd62);
        drain_picks();
    endtask

    task automatic test_deadline_saturation();
        write_register(REG_BACKEND_COUNT, 16'd2);
        write_register(REG_RETRY_SECONDS, 16'hFFFF);
        send_request(OP_SELECT, 32'hFFFF_FF00);
        send_request(OP_FAIL, 32'hFFFF_FF00);
        send_request(OP_FAIL, 32'hFFFF_FFFF);
        drain_picks();
    endtask

    task automatic test_count_limits();
        write_register(REG_BACKEND_COUNT, 16'd0);
        send_request(OP_SELECT, 32'd1000);
        send_request(OP_FAIL, 32'd1000);
        send_request(OP_SELECT, 32'd1001);
        drain_picks();
        write_register(REG_BACKEND_COUNT, 16'd31);
        send_request(OP_SELECT, 32'd1002);
        send_request(OP_SELECT, 32'd1003);
        send_request(OP_FAIL, 32'd1004);
        drain_picks();
    endtask

    task automatic test_cursor_wrap();
        int k;
        write_register(REG_BACKEND_COUNT, 16'd16);
        write_register(REG_RETRY_SECONDS, 16'd5);
        for (k = 0; k < 6; k++)
            send_request(OP_SELECT, 32'd2000 + k);
        drain_picks();
        // pool cursor now sits above the new count
        write_register(REG_BACKEND_COUNT, 16'd3);
        send_request(OP_SELECT, 32'd2010);
        send_request(OP_SELECT, 32'd2011);
        drain_picks();
    endtask

    task automatic test_output_backpressure();
        int k;
        write_register(REG_BACKEND_COUNT, 16'd4);
        write_register(REG_RETRY_SECONDS, 16'd3);
        gaps_on = 1'b0;
        rsp_hold_cycles = 300;
        for (k = 0; k < 24; k++)
            send_request((k % 3 == 2) ? OP_FAIL : OP_SELECT, 32'd3000 + k);
        // sender waits only for each accept; drain_picks then waits for all results
        drain_picks();
        for (k = 0; k < 16; k++)
            send_request((k % 4 == 1) ? OP_FAIL : OP_SELECT, 32'd3030 + k);
        drain_picks();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int                phase;
        int                k;
        int                count_choice;
        int                retry_choice;
        logic [TIME_W-1:0] clock_s;
        logic              op;
        clock_s = $urandom();
        for (phase = 0; phase < 9; phase++)
        begin
            drain_picks();
            count_choice = (phase == 0) ? 16 : (phase == 1) ? 31 : (phase == 2) ? 0 :
                           (phase == 3) ? 1 : $urandom_range(0, 31);
            retry_choice = (phase == 4) ? 65535 : (phase % 3 == 0) ? $urandom_range(0, 8) :
                           (phase % 3 == 1) ? $urandom_range(1, 40) : 0;
            write_register(REG_BACKEND_COUNT, CFG_W'(count_choice));
            write_register(REG_RETRY_SECONDS, CFG_W'(retry_choice));
            gaps_on = (phase % 3) != 2;
            for (k = 0; k < 160; k++)
            begin
                if ($urandom_range(0, 49) == 0)
                    clock_s = $urandom();
                else
                    clock_s = clock_s + $urandom_range(0, 4);
                op = ($urandom_range(0, 99) < 35) ? OP_FAIL : OP_SELECT;
                send_request(op, clock_s);
            end
        end
        drain_picks();
        gaps_on = 1'b1;
    endtask

    initial
    begin : rsp_checker
        int    gap;
        pick_t want;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = (rsp_hold_cycles > 0) ? rsp_hold_cycles : draw_gap();
            rsp_hold_cycles = 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            if (pending_picks.size() == 0)
            begin
                $error("unexpected result: found %0d backend_index %0d",
                       rsp_ch.found, rsp_ch.backend_index);
                error_count++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (rsp_ch.found !== want.found)
                begin
                    $error("found mismatch: expected %0d, actual %0d", want.found, rsp_ch.found);
                    error_count++;
                end
                if (rsp_ch.backend_index !== want.backend_index)
                begin
                    $error("backend_index mismatch: expected %0d, actual %0d",
                           want.backend_index, rsp_ch.backend_index);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_backend_round_robin_health_select_unit failed");
            $finish;
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < NUM_BACKENDS; k++)
        begin
            backend_dead[k] = 1'b0;
            revive_at[k]    = '0;
        end
        pool_pos  = '0;
        probe_pos = '0;
        prev_pick = '0;
        count_reg = COUNT_RESET;
        retry_reg = RETRY_RESET;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= OP_SELECT;
        req_ch.now_seconds <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_failure_before_pick();
        test_zero_retry();
        test_deadline_saturation();
        test_count_limits();
        test_cursor_wrap();
        test_output_backpressure();
        test_random_traffic();

        drain_picks();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_picks.size() == 0)
            $display("tb_backend_round_robin_health_select_unit passed");
        else
            $display("tb_backend_round_robin_health_select_unit failed");
        $finish;
    end

endmodule
